>>> rtl/bdat_pkg.sv
// Shared types for the ball detector with average threshold and calibration.
// No dependencies; the request interface and the top level import it.
`default_nettype none

package bdat_pkg;

	typedef enum logic [1:0] {
		REQ_DETECT  = 2'd0,
		REQ_CAL_OUT = 2'd1,
		REQ_CAL_IN  = 2'd2,
		REQ_STORE   = 2'd3
	} req_t;

	// Start threshold at reset before masking to the sample width.
	localparam int unsigned START_THRESHOLD_RESET = 512;

endpackage

`default_nettype wire

>>> rtl/bdat_if.sv
// Valid/ready channel interfaces for the ball detector: request words,
// result words and start threshold writes. Depends on bdat_pkg.
`default_nettype none

interface bdat_req_if
	import bdat_pkg::*;
	#(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	req_t                   req_type;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output req_type, output sample, input ready);
	modport sink (input valid, input req_type, input sample, output ready);
endinterface

interface bdat_res_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic                   ball_present;
	logic [SAMPLE_BITS-1:0] window_average;
	logic [SAMPLE_BITS-1:0] active_threshold;
	modport source (output valid, output ball_present, output window_average,
		output active_threshold, input ready);
	modport sink (input valid, input ball_present, input window_average,
		input active_threshold, output ready);
endinterface

interface bdat_cfg_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ball_detector_avg_threshold_cal.sv
// Ball detector top level: moving average threshold detection with min/max
// calibration. Depends on bdat_pkg and the channel interfaces in bdat_if.sv.
//
// Usage:
//   req  - request words: req_type (detect, calibrate outside, calibrate
//          inside, store) and a sample. One result word per request.
//   res  - result words: ball_present, window_average, active_threshold.
//   cfg  - start threshold writes; always ready, take effect at once.
// A request is captured into an input stage, processed by a single pass of
// logic against the window and calibration registers, and lands in the
// result register. Throughput is one word per cycle while the receiver
// takes results; the window sum and the reciprocal multiply that divides it
// by the window length sit in combinational logic between the stages.
// When the receiver stalls, the result holds and the input stage still takes
// one more word, then ready drops until the result is taken.
// Reset clears the window to zero, the outside minimum to all ones, the
// inside maximum and calibrated threshold to zero, and sets the start
// threshold to 512 (masked to the sample width).
`default_nettype none

module ball_detector_avg_threshold_cal
	import bdat_pkg::*;
	#(
		parameter int WINDOW_LENGTH = 5,
		parameter int SAMPLE_BITS   = 10
	)
	(
		input  wire logic clk,
		input  wire logic arst_n,
		bdat_req_if.sink  req,
		bdat_res_if.source res,
		bdat_cfg_if.sink  cfg
	);

	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
	localparam logic [SAMPLE_BITS-1:0] START_RESET =
		SAMPLE_BITS'(START_THRESHOLD_RESET % (1 << SAMPLE_BITS));
	// Reciprocal of the window length, exact for every sum that fits in SUM_W bits
	localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
	localparam int PROD_W    = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] DIV_RECIP = (SUM_W+1)'(
		((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

	// Input stage
	logic                   valid_s1;
	req_t                   req_type_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// Block state
	logic [SAMPLE_BITS-1:0] start_threshold_q;
	logic [SAMPLE_BITS-1:0] window_q [WINDOW_LENGTH];
	logic [SAMPLE_BITS-1:0] outside_min_q;
	logic [SAMPLE_BITS-1:0] inside_max_q;
	logic [SAMPLE_BITS-1:0] cal_threshold_q;
	logic                   cal_valid_q;

	// Result register
	logic                   res_valid_q;
	logic                   ball_present_q;
	logic [SAMPLE_BITS-1:0] window_average_q;
	logic [SAMPLE_BITS-1:0] active_threshold_q;

	// Next values
	logic                   advance;
	logic [SAMPLE_BITS-1:0] window_d [WINDOW_LENGTH];
	logic [SUM_W-1:0]       window_sum;
	logic [PROD_W-1:0]      avg_prod;
	logic [SAMPLE_BITS-1:0] avg_d;
	logic [SAMPLE_BITS-1:0] outside_min_d;
	logic [SAMPLE_BITS-1:0] inside_max_d;
	logic [SAMPLE_BITS-1:0] cal_threshold_d;
	logic                   cal_valid_d;
	logic [SAMPLE_BITS-1:0] threshold_d;
	logic [SAMPLE_BITS:0]   mid_sum;
	logic                   present_d;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_comb begin
		for (int k = 0; k < WINDOW_LENGTH; k++) begin
			window_d[k] = window_q[k];
		end
		if (req_type_s1 == REQ_DETECT) begin
			for (int k = WINDOW_LENGTH - 1; k > 0; k--) begin
				window_d[k] = window_q[k-1];
			end
			window_d[0] = sample_s1;
		end
	end

	always_comb begin
		window_sum = '0;
		for (int k = 0; k < WINDOW_LENGTH; k++) begin
			window_sum = window_sum + SUM_W'(window_d[k]);
		end
		avg_prod = {{(SUM_W+1){1'b0}}, window_sum} * {{SUM_W{1'b0}}, DIV_RECIP};
		avg_d    = avg_prod[DIV_SHIFT +: SAMPLE_BITS];
	end

	always_comb begin
		outside_min_d   = outside_min_q;
		inside_max_d    = inside_max_q;
		cal_threshold_d = cal_threshold_q;
		cal_valid_d     = cal_valid_q;
		mid_sum         = {1'b0, outside_min_q} + {1'b0, inside_max_q};
		case (req_type_s1)
			REQ_DETECT: begin
			end
			REQ_CAL_OUT: begin
				if (sample_s1 < outside_min_q) outside_min_d = sample_s1;
			end
			REQ_CAL_IN: begin
				if (sample_s1 > inside_max_q) inside_max_d = sample_s1;
			end
			REQ_STORE: begin
				cal_threshold_d = mid_sum[SAMPLE_BITS:1];
				cal_valid_d     = 1'b1;
			end
			default: begin
			end
		endcase
		threshold_d = cal_valid_d ? cal_threshold_d : start_threshold_q;
		present_d   = (req_type_s1 == REQ_DETECT) && (avg_d < threshold_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			sample_s1   <= req.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_threshold_q <= START_RESET;
			for (int k = 0; k < WINDOW_LENGTH; k++) begin
				window_q[k] <= '0;
			end
			outside_min_q   <= '1;
			inside_max_q    <= '0;
			cal_threshold_q <= '0;
			cal_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) start_threshold_q <= cfg.data;
			if (advance) begin
				for (int k = 0; k < WINDOW_LENGTH; k++) begin
					window_q[k] <= window_d[k];
				end
				outside_min_q   <= outside_min_d;
				inside_max_q    <= inside_max_d;
				cal_threshold_q <= cal_threshold_d;
				cal_valid_q     <= cal_valid_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ball_present_q     <= present_d;
			window_average_q   <= avg_d;
			active_threshold_q <= threshold_d;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.ball_present     = ball_present_q;
	assign res.window_average   = window_average_q;
	assign res.active_threshold = active_threshold_q;

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for ball_detector_avg_threshold_cal: a directed table, then random
// request words with idle gaps and result stalls; checks use table or predictor values.
// Depends on bdat_pkg, the channel interfaces in bdat_if.sv and the top level.
module tb;
	import bdat_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W       = 10;
	localparam int WIN_LEN     = 5;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 130;

	typedef struct packed {
		logic             present;
		logic [SMP_W-1:0] avg;
		logic [SMP_W-1:0] thr;
	} outcome_t;

	typedef struct {
		bit       on;
		outcome_t val;
	} typed_t;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		req_t             op;
		logic [SMP_W-1:0] smp;
		bit               typed;
		outcome_t         val;
	} row_t;

	logic clk;
	logic arst_n;

	bdat_req_if #(.SAMPLE_BITS(SMP_W)) req_ch ();
	bdat_res_if #(.SAMPLE_BITS(SMP_W)) res_ch ();
	bdat_cfg_if #(.SAMPLE_BITS(SMP_W)) cfg_ch ();

	ball_detector_avg_threshold_cal #(
		.WINDOW_LENGTH(WIN_LEN),
		.SAMPLE_BITS  (SMP_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// detector state as the predictor sees it
	logic [SMP_W-1:0] win [WIN_LEN] = '{default: '0};
	logic [SMP_W-1:0] low_seen  = '1;
	logic [SMP_W-1:0] high_seen = '0;
	logic [SMP_W-1:0] cal_thr   = '0;
	logic [SMP_W-1:0] start_thr = SMP_W'(START_THRESHOLD_RESET);
	bit               cal_on    = 0;

	outcome_t pending_outcomes [$];
	typed_t   table_checks [$];
	row_t     steps [$];
	int       mismatches = 0;
	int       quiet = 0;
	int       hold_left = 0;
	bit       send_idle = 1;
	bit       stall_on = 1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic outcome_t detector_outcome(req_t op, logic [SMP_W-1:0] smp);
		outcome_t o;
		int sum;
		o = '0;
		case (op)
			REQ_DETECT: begin
				for (int k = WIN_LEN - 1; k > 0; k--) win[k] = win[k-1];
				win[0] = smp;
			end
			REQ_CAL_OUT: begin
				if (smp < low_seen) low_seen = smp;
			end
			REQ_CAL_IN: begin
				if (smp > high_seen) high_seen = smp;
			end
			default: begin
				cal_thr = SMP_W'((int'(low_seen) + int'(high_seen)) / 2);
				cal_on  = 1;
			end
		endcase
		sum = 0;
		foreach (win[k]) sum += win[k];
		o.avg = SMP_W'(sum / WIN_LEN);
		o.thr = cal_on ? cal_thr : start_thr;
		if (op == REQ_DETECT) o.present = (o.avg < o.thr);
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function void add_req(req_t op, int smp);
		steps.push_back('{ROW_REQ, op, SMP_W'(smp), 1'b0, '0});
	endfunction

	function void add_chk(req_t op, int smp, bit p, int avg, int thr);
		outcome_t o;
		o.present = p;
		o.avg     = SMP_W'(avg);
		o.thr     = SMP_W'(thr);
		steps.push_back('{ROW_REQ, op, SMP_W'(smp), 1'b1, o});
	endfunction

	function void add_cfg(int v);
		steps.push_back('{ROW_CFG, REQ_DETECT, SMP_W'(v), 1'b0, '0});
	endfunction

	task automatic report_mismatch(input string field, input logic [SMP_W-1:0] got,
		input logic [SMP_W-1:0] want);
		$display("%0t ns: %s mismatch, got %0d, want %0d", $time, field, got, want);
		mismatches++;
	endtask

	task automatic send_word(req_t op, logic [SMP_W-1:0] smp, bit typed, outcome_t val);
		typed_t t;
		int gap;
		t.on  = typed;
		t.val = val;
		table_checks.push_back(t);
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.sample   <= smp;
		do @(posedge clk); while (!req_ch.ready);
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and hold until every expected word has come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic write_start(logic [SMP_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin : take_req
		outcome_t o;
		typed_t t;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			o = detector_outcome(req_ch.req_type, req_ch.sample);
			t = table_checks.pop_front();
			pending_outcomes.push_back(t.on ? t.val : o);
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) start_thr = cfg_ch.data;
	end

	always @(posedge clk) begin : check_res
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result word", res_ch.window_average, '0);
			end else begin
				want = pending_outcomes.pop_front();
				if (res_ch.ball_present !== want.present)
					report_mismatch("ball_present", SMP_W'(res_ch.ball_present),
						SMP_W'(want.present));
				if (res_ch.window_average !== want.avg)
					report_mismatch("window_average", res_ch.window_average, want.avg);
				if (res_ch.active_threshold !== want.thr)
					report_mismatch("active_threshold", res_ch.active_threshold, want.thr);
			end
		end
	end

	// result side back-pressure: short stalls mostly, now and then a long one
	always @(posedge clk) begin : drive_res_ready
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (stall_on && $urandom_range(99) < 25) begin
			hold_left = ($urandom_range(99) < 85) ? $urandom_range(3, 1)
				: $urandom_range(40, 8);
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		req_t op;
		logic [SMP_W-1:0] smp;
		int r;
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_DETECT;
		req_ch.sample   = '0;
		res_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;

		// reset values, full-scale window, start threshold extremes
		add_chk(REQ_DETECT, 0, 1, 0, 512);
		repeat (4) add_req(REQ_DETECT, 1023);
		add_chk(REQ_DETECT, 1023, 0, 1023, 512);
		add_cfg(1023);
		add_chk(REQ_DETECT, 1023, 0, 1023, 1023);
		add_req(REQ_DETECT, 0);
		add_cfg(0);
		repeat (3) add_req(REQ_DETECT, 0);
		add_chk(REQ_DETECT, 0, 0, 0, 0);
		// store with untouched trackers
		add_chk(REQ_STORE, 1023, 0, 0, 511);
		add_req(REQ_DETECT, 1023);
		add_req(REQ_CAL_OUT, 1023);
		add_req(REQ_CAL_OUT, 700);
		add_req(REQ_CAL_IN, 300);
		// minimum above maximum
		add_chk(REQ_STORE, 0, 0, 204, 500);
		add_req(REQ_CAL_OUT, 0);
		add_req(REQ_CAL_IN, 1023);
		add_chk(REQ_STORE, 0, 0, 204, 511);
		// start threshold write after a store must not matter
		add_cfg(1023);
		add_req(REQ_DETECT, 0);
		add_req(REQ_STORE, 1023);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG) begin
				settle();
				write_start(steps[i].smp);
			end else begin
				send_word(steps[i].op, steps[i].smp, steps[i].typed, steps[i].val);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			send_idle = (p % 3 != 1);
			stall_on  = (p % 4 != 2);
			repeat (PHASE_WORDS) begin
				r = $urandom_range(99);
				if (r < 60) begin
					op  = REQ_DETECT;
					smp = SMP_W'($urandom_range(1023));
				end else if (r < 72) begin
					op  = REQ_CAL_OUT;
					smp = SMP_W'($urandom_range(1023, 300));
				end else if (r < 84) begin
					op  = REQ_CAL_IN;
					smp = SMP_W'($urandom_range(700, 0));
				end else begin
					op  = REQ_STORE;
					smp = SMP_W'($urandom_range(1023));
				end
				send_word(op, smp, 1'b0, '0);
			end
			settle();
			if (p % 3 == 0)
				write_start('0);
			else if (p % 3 == 1)
				write_start('1);
			else
				write_start(SMP_W'($urandom_range(1023)));
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
